### rtl/core/mmp_pkg.sv
// shared types, codes and constants of the modular matrix power block
package mmp_pkg;

    // modulus and barrett reciprocal floor(2^60 / prime)
    localparam logic [29:0] PRIME   = 30'd998244353;
    localparam logic [63:0] MU_FULL = 64'h1000_0000_0000_0000 / 64'd998244353;
    localparam logic [30:0] MU      = MU_FULL[30:0];

    // fixed field widths
    localparam int VAL_W      = 30;
    localparam int IDX_W      = 6;
    localparam int DIM_W      = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    // item opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIMENSION = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT  = 8'd1;

    // datapath command kinds
    typedef enum logic [2:0] {
        DP_NONE,
        DP_WRITE_BASE,
        DP_READ,
        DP_INIT,
        DP_MAC,
        DP_COPY
    } dp_kind_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_INIT,
        S_INIT_WAIT,
        S_CHECK_MUL,
        S_CHECK_SQR,
        S_MAC,
        S_MAC_WAIT,
        S_COPY,
        S_COPY_WAIT,
        S_DONE
    } ctrl_state_t;

    // command from controller to datapath
    typedef struct packed {
        dp_kind_t               kind;
        logic                   phase;
        logic                   first;
        logic                   last;
        logic                   blank;
        logic                   load_done;
        logic [IDX_W-1:0]       i;
        logic [IDX_W-1:0]       j;
        logic [IDX_W-1:0]       k;
        logic [VAL_W-1:0]       data;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

### rtl/core/mmp_if.sv
// channel interfaces: item input, result output and configuration write
interface mmp_item_if;
    import mmp_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       op;
    logic [3:0]       row;
    logic [3:0]       col;
    logic [VAL_W-1:0] entry_value;
    modport source (output valid, op, row, col, entry_value, input ready);
    modport sink   (input valid, op, row, col, entry_value, output ready);
endinterface

interface mmp_result_if;
    import mmp_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] value;
    logic             done_res;
    modport source (output valid, value, done_res, input ready);
    modport sink   (input valid, value, done_res, output ready);
endinterface

interface mmp_cfg_if;
    import mmp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/mmp_ram.sv
// generic ram: one write port, two registered read ports
module mmp_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]                          rd_data_a,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]                          rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### rtl/core/mmp_datapath.sv
// datapath: matrix stores, modular multiply-accumulate pipeline, result register
module mmp_datapath #(
    parameter int MAX_DIM = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mmp_pkg::dp_cmd_t    cmd,
    output mmp_pkg::dp_status_t status,
    mmp_result_if.source        results
);
    import mmp_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int FW    = 2 * IDX_W + 1;

    typedef struct packed {
        logic          valid;
        logic          first;
        logic          last;
        logic [AW-1:0] addr;
    } mac_tag_t;

    function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
        logic [FW-1:0] full;
        full = FW'(r) * FW'(MAX_DIM) + FW'(c);
        return full[AW-1:0];
    endfunction

    logic [AW-1:0]    addr_ij;
    logic [AW-1:0]    addr_ik;
    logic [AW-1:0]    addr_kj;
    logic [VAL_W-1:0] wr_reduced;
    logic [VAL_W-1:0] ident_val;

    logic [VAL_W-1:0] base_rd;
    logic [VAL_W-1:0] res_rd;
    logic [VAL_W-1:0] scr_rd_a;
    logic [VAL_W-1:0] scr_rd_b;
    logic [VAL_W-1:0] prod_rd;

    logic             res_we;
    logic [AW-1:0]    res_wr_addr;
    logic [VAL_W-1:0] res_wr_data;
    logic             scr_we;
    logic [VAL_W-1:0] scr_wr_data;

    dp_kind_t         d1_kind_reg;
    logic             d1_phase_reg;
    logic             d1_blank_reg;
    logic [AW-1:0]    d1_addr_reg;

    mac_tag_t         tag_in;
    mac_tag_t         tag_reg [1:5];

    logic [VAL_W-1:0] op_a;
    logic [59:0]      x_reg;
    logic [59:0]      x2_reg;
    logic [61:0]      q2_reg;
    logic [62:0]      qp;
    logic [31:0]      r_next;
    logic [31:0]      r_reg;
    logic [VAL_W-1:0] rc_next;
    logic [VAL_W-1:0] rc_reg;
    logic [VAL_W-1:0] acc_reg;
    logic [VAL_W:0]   sum_raw;
    logic [VAL_W-1:0] sum;

    logic             out_valid_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic             out_done_reg;

    // addresses and write values
    assign addr_ij    = cell_addr(cmd.i, cmd.j);
    assign addr_ik    = cell_addr(cmd.i, cmd.k);
    assign addr_kj    = cell_addr(cmd.k, cmd.j);
    assign wr_reduced = (cmd.data >= PRIME) ? cmd.data - PRIME : cmd.data;
    assign ident_val  = (cmd.i == cmd.j) ? VAL_W'(1) : '0;

    // registered command fields for writes that follow a registered read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_kind_reg <= DP_NONE;
        end
        else
        begin
            d1_kind_reg <= cmd.kind;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_phase_reg <= cmd.phase;
        d1_blank_reg <= cmd.blank;
        d1_addr_reg  <= addr_ij;
    end

    // write port selection
    assign res_we      = (cmd.kind == DP_INIT) || (d1_kind_reg == DP_COPY && !d1_phase_reg);
    assign res_wr_addr = (cmd.kind == DP_INIT) ? addr_ij : d1_addr_reg;
    assign res_wr_data = (cmd.kind == DP_INIT) ? ident_val : prod_rd;
    assign scr_we      = (d1_kind_reg == DP_INIT) || (d1_kind_reg == DP_COPY && d1_phase_reg);
    assign scr_wr_data = (d1_kind_reg == DP_INIT) ? base_rd : prod_rd;

    // matrix stores
    mmp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_base (
        .clk       (clk),
        .we        (cmd.kind == DP_WRITE_BASE),
        .wr_addr   (addr_ij),
        .wr_data   (wr_reduced),
        .rd_addr_a (addr_ij),
        .rd_data_a (base_rd),
        .rd_addr_b (addr_ij),
        .rd_data_b ()
    );

    mmp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_result (
        .clk       (clk),
        .we        (res_we),
        .wr_addr   (res_wr_addr),
        .wr_data   (res_wr_data),
        .rd_addr_a (addr_ik),
        .rd_data_a (res_rd),
        .rd_addr_b (addr_ik),
        .rd_data_b ()
    );

    mmp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_scratch (
        .clk       (clk),
        .we        (scr_we),
        .wr_addr   (d1_addr_reg),
        .wr_data   (scr_wr_data),
        .rd_addr_a (addr_ik),
        .rd_data_a (scr_rd_a),
        .rd_addr_b (addr_kj),
        .rd_data_b (scr_rd_b)
    );

    mmp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_product (
        .clk       (clk),
        .we        (tag_reg[5].valid && tag_reg[5].last),
        .wr_addr   (tag_reg[5].addr),
        .wr_data   (sum),
        .rd_addr_a (addr_ij),
        .rd_data_a (prod_rd),
        .rd_addr_b (addr_ij),
        .rd_data_b ()
    );

    // pipeline tags
    assign tag_in = '{valid: (cmd.kind == DP_MAC), first: cmd.first,
                      last: cmd.last, addr: addr_ij};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= 5; s++)
            begin
                tag_reg[s] <= '0;
            end
        end
        else
        begin
            tag_reg[1] <= tag_in;
            for (int s = 2; s <= 5; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    // product, barrett quotient estimate, remainder, correction
    assign op_a    = d1_phase_reg ? scr_rd_a : res_rd;
    assign qp      = 63'(q2_reg[61:31]) * 63'(PRIME);
    assign r_next  = x2_reg[31:0] - qp[31:0];

    always_comb
    begin
        if (r_reg >= 32'(2 * 64'(PRIME)))
        begin
            rc_next = VAL_W'(r_reg - 32'(2 * 64'(PRIME)));
        end
        else if (r_reg >= 32'(PRIME))
        begin
            rc_next = VAL_W'(r_reg - 32'(PRIME));
        end
        else
        begin
            rc_next = VAL_W'(r_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= 60'(op_a) * 60'(scr_rd_b);
        q2_reg <= 62'(x_reg[59:29]) * 62'(MU);
        x2_reg <= x_reg;
        r_reg  <= r_next;
        rc_reg <= rc_next;
    end

    // modular accumulation
    assign sum_raw = (tag_reg[5].first ? (VAL_W+1)'(0) : (VAL_W+1)'(acc_reg))
                     + (VAL_W+1)'(rc_reg);
    assign sum     = (sum_raw >= (VAL_W+1)'(PRIME)) ? VAL_W'(sum_raw - (VAL_W+1)'(PRIME))
                                                    : VAL_W'(sum_raw);

    always_ff @(posedge clk)
    begin
        if (tag_reg[5].valid)
        begin
            acc_reg <= sum;
        end
    end

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (d1_kind_reg == DP_READ || cmd.load_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d1_kind_reg == DP_READ)
        begin
            out_value_reg <= d1_blank_reg ? '0 : res_rd;
            out_done_reg  <= 1'b0;
        end
        else if (cmd.load_done)
        begin
            out_value_reg <= '0;
            out_done_reg  <= 1'b1;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.value    = out_value_reg;
    assign results.done_res = out_done_reg;
    assign status.out_free  = !out_valid_reg || results.ready;

endmodule

### rtl/core/mmp_ctrl.sv
// controller: configuration registers, item decode and power sequencing
module mmp_ctrl #(
    parameter int MAX_DIM  = 16,
    parameter int EXP_BITS = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    mmp_item_if.sink            items,
    mmp_cfg_if.sink             cfg,
    output mmp_pkg::dp_cmd_t    cmd,
    input  mmp_pkg::dp_status_t status
);
    import mmp_pkg::*;

    localparam int         IW          = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
    localparam logic [3:0] WAIT_CYCLES = 4'd8;

    ctrl_state_t         state_reg, state_next;
    logic [4:0]          dim_reg;
    logic [EXP_BITS-1:0] exp_reg;
    logic [EXP_BITS-1:0] esh_reg, esh_next;
    logic [IW-1:0]       i_reg, i_next;
    logic [IW-1:0]       j_reg, j_next;
    logic [IW-1:0]       k_reg, k_next;
    logic                phase_reg, phase_next;
    logic [3:0]          wait_reg, wait_next;

    logic [DIM_W-1:0]    n;
    logic                last_i, last_j, last_k;
    logic                accept;
    logic                in_store, in_dim;

    // effective dimension and loop ends
    always_comb
    begin
        if (dim_reg == 5'd0)
        begin
            n = DIM_W'(1);
        end
        else if (DIM_W'(dim_reg) > DIM_W'(MAX_DIM))
        begin
            n = DIM_W'(MAX_DIM);
        end
        else
        begin
            n = DIM_W'(dim_reg);
        end
    end

    assign last_i   = (DIM_W'(i_reg) == n - DIM_W'(1));
    assign last_j   = (DIM_W'(j_reg) == n - DIM_W'(1));
    assign last_k   = (DIM_W'(k_reg) == n - DIM_W'(1));
    assign in_store = (DIM_W'(items.row) < DIM_W'(MAX_DIM))
                      && (DIM_W'(items.col) < DIM_W'(MAX_DIM));
    assign in_dim   = (DIM_W'(items.row) < n) && (DIM_W'(items.col) < n);

    assign items.ready = (state_reg == S_IDLE) && status.out_free;
    assign accept      = items.valid && items.ready;
    assign cfg.ready   = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= 5'd1;
            exp_reg <= EXP_BITS'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DIMENSION: dim_reg <= cfg.data[4:0];
                REG_EXPONENT:  exp_reg <= cfg.data[EXP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // state and loop registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            esh_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            phase_reg <= 1'b0;
            wait_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            esh_reg   <= esh_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (items.op)
                        OP_START: state_next = S_INIT;
                        OP_READ:  state_next = S_RD_WAIT;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_RD_WAIT:   state_next = S_IDLE;
            S_INIT:      if (last_i && last_j) state_next = S_INIT_WAIT;
            S_INIT_WAIT: if (wait_reg == '0) state_next = S_CHECK_MUL;
            S_CHECK_MUL: state_next = esh_reg[0] ? S_MAC : S_CHECK_SQR;
            S_CHECK_SQR: state_next = ((esh_reg >> 1) == '0) ? S_DONE : S_MAC;
            S_MAC:       if (last_i && last_j && last_k) state_next = S_MAC_WAIT;
            S_MAC_WAIT:  if (wait_reg == '0) state_next = S_COPY;
            S_COPY:      if (last_i && last_j) state_next = S_COPY_WAIT;
            S_COPY_WAIT:
            begin
                if (wait_reg == '0)
                begin
                    state_next = phase_reg ? S_CHECK_MUL : S_CHECK_SQR;
                end
            end
            S_DONE:      if (status.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // loop counters, exponent shifter, drain timer
    always_comb
    begin
        esh_next   = esh_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        phase_next = phase_reg;
        wait_next  = (wait_reg != '0) ? wait_reg - 4'd1 : wait_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && items.op == OP_START)
                begin
                    esh_next = exp_reg;
                    i_next   = '0;
                    j_next   = '0;
                    k_next   = '0;
                end
            end
            S_INIT, S_COPY:
            begin
                if (last_j)
                begin
                    j_next = '0;
                    if (last_i)
                    begin
                        i_next    = '0;
                        wait_next = WAIT_CYCLES;
                    end
                    else
                    begin
                        i_next = i_reg + IW'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
            end
            S_MAC:
            begin
                if (last_k)
                begin
                    k_next = '0;
                    if (last_j)
                    begin
                        j_next = '0;
                        if (last_i)
                        begin
                            i_next    = '0;
                            wait_next = WAIT_CYCLES;
                        end
                        else
                        begin
                            i_next = i_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + IW'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end
            S_CHECK_MUL: phase_next = 1'b0;
            S_CHECK_SQR: phase_next = 1'b1;
            S_COPY_WAIT:
            begin
                if (wait_reg == '0 && phase_reg)
                begin
                    esh_next = esh_reg >> 1;
                end
            end
            default: ;
        endcase
    end

    // datapath command
    always_comb
    begin
        cmd       = '0;
        cmd.kind  = DP_NONE;
        cmd.phase = phase_reg;
        cmd.i     = IDX_W'(i_reg);
        cmd.j     = IDX_W'(j_reg);
        cmd.k     = IDX_W'(k_reg);
        cmd.data  = items.entry_value;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.i = IDX_W'(items.row);
                    cmd.j = IDX_W'(items.col);
                    cmd.k = IDX_W'(items.col);
                    case (items.op)
                        OP_WRITE: cmd.kind = in_store ? DP_WRITE_BASE : DP_NONE;
                        OP_READ:
                        begin
                            cmd.kind  = DP_READ;
                            cmd.blank = !in_dim;
                        end
                        default:  cmd.kind = DP_NONE;
                    endcase
                end
            end
            S_INIT: cmd.kind = DP_INIT;
            S_MAC:
            begin
                cmd.kind  = DP_MAC;
                cmd.first = (k_reg == '0);
                cmd.last  = last_k;
            end
            S_COPY: cmd.kind = DP_COPY;
            S_DONE: cmd.load_done = status.out_free;
            S_RD_WAIT, S_INIT_WAIT, S_CHECK_MUL, S_CHECK_SQR, S_MAC_WAIT,
            S_COPY_WAIT: ;
            default: ;
        endcase
    end

endmodule

### rtl/core/modular_matrix_power_top.sv
// top level of the modular matrix power block
// Raises a base matrix to the configured exponent modulo 998244353.
// Channels: items (op, row, col, entry_value) in, results (value, done_res)
// out, cfg writes dimension (index 0) and exponent (index 1). The user must
// write them only while the block is idle; the block does not enforce this.
// cfg is always ready. A write beat gives no result. A read beat waits on the
// registered store read and gives one result beat with the entry, or zero
// outside the dimension. A start beat runs the power: an n*n sweep that sets
// the identity and copies the base, then for each exponent bit up to the
// highest set one a result multiply (when the bit is set) and a squaring
// (except after the highest bit), each n^3 multiply-accumulates through the
// single pipeline, then an n*n copy, each followed by a drain. Then one done
// beat is given.
// Items are taken only while idle and the result register is free or being
// taken, so a stalled receiver holds the block after one pending beat.
// Reset sets dimension 1 and exponent 1; matrix contents are undefined until
// written, with no clearing pass.
module modular_matrix_power_top #(
    parameter int MAX_DIM  = 16,
    parameter int EXP_BITS = 63
) (
    input  logic         clk,
    input  logic         rst_n,
    mmp_item_if.sink     items,
    mmp_result_if.source results,
    mmp_cfg_if.sink      cfg
);
    import mmp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // control
    mmp_ctrl #(.MAX_DIM(MAX_DIM), .EXP_BITS(EXP_BITS)) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items),
        .cfg    (cfg),
        .cmd    (cmd),
        .status (status)
    );

    // stores and arithmetic
    mmp_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .results (results)
    );

endmodule
